### src/time_of_day_clock_with_setup_blink_top_defines.svh
// ----------------------------------------------------------------------------
// Time-of-day clock assertion macros
// Shared concurrent assertion helpers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIME_OF_DAY_CLOCK_WITH_SETUP_BLINK_TOP_DEFINES_SVH
`define TIME_OF_DAY_CLOCK_WITH_SETUP_BLINK_TOP_DEFINES_SVH

// condition holds at every edge outside reset
`define TDC_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define TDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tdc_pkg.sv
// ----------------------------------------------------------------------------
// Time-of-day clock package
// Item types, state record, configuration record and shared codes.
// ----------------------------------------------------------------------------
package tdc_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_ADJUST  = 2'd1;
    localparam logic [1:0] KIND_SET_FLD = 2'd2;
    localparam logic [1:0] KIND_SET_VIS = 2'd3;

    // edited field codes
    localparam logic [1:0] FIELD_NONE   = 2'd0;
    localparam logic [1:0] FIELD_MINUTE = 2'd1;
    localparam logic [1:0] FIELD_HOUR   = 2'd2;

    // register indexes
    localparam logic [1:0] REG_POWER_SAVE = 2'd0;
    localparam logic [1:0] REG_TICKS_SEC  = 2'd1;
    localparam logic [1:0] REG_TICKS_BLNK = 2'd2;
    localparam logic [1:0] REG_OFF_DELAY  = 2'd3;

    // time limits and reset values
    localparam logic [5:0] LAST_SECOND    = 6'd59;
    localparam logic [5:0] LAST_MINUTE    = 6'd59;
    localparam logic [4:0] LAST_HOUR      = 5'd23;
    localparam logic [4:0] HOUR_RESET     = 5'd12;
    localparam logic [9:0] TPS_RESET      = 10'd1000;
    localparam logic [7:0] TPB_RESET      = 8'd200;
    localparam logic [5:0] OFF_DLY_RESET  = 6'd30;

    typedef struct packed {
        logic [1:0] kind;
        logic       key_pressed;
        logic       step_down;
        logic [1:0] setup_field;
        logic       visible_in;
    } in_item_t;

    typedef struct packed {
        logic [4:0] hour_out;
        logic [5:0] minute_out;
        logic [5:0] second_out;
        logic       show_hour_out;
        logic       show_minute_out;
        logic       show_dot_out;
        logic       display_update;
        logic       display_enable;
        logic       display_disable;
        logic       minute_event;
        logic       tick_mark;
    } out_item_t;

    typedef struct packed {
        logic       power_save;
        logic [9:0] ticks_per_second;
        logic [7:0] ticks_per_blink;
        logic [5:0] off_delay;
    } cfg_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } tod_t;

    typedef struct packed {
        logic [9:0] sub_second_count;
        logic [7:0] blink_count;
        tod_t       tod;
        logic [5:0] idle_seconds;
        logic       show_hour;
        logic       show_minute;
        logic       show_dot;
        logic       visible;
        logic [1:0] edit_field;
    } state_t;

endpackage

### src/tdc_step.sv
// ----------------------------------------------------------------------------
// Time-of-day clock item step
// Next state and result for one item, as one short combinational pass.
// ----------------------------------------------------------------------------
module tdc_step (
    input  tdc_pkg::state_t    st,
    input  tdc_pkg::cfg_t      cfg,
    input  tdc_pkg::in_item_t  item,
    output tdc_pkg::state_t    st_next,
    output tdc_pkg::out_item_t res
);
    import tdc_pkg::*;

    // one second forward with minute and hour carry
    function automatic tod_t next_second(input tod_t t);
        tod_t r;
        r = t;
        if (t.seconds >= LAST_SECOND)
        begin
            r.seconds = '0;
            r.minutes = (t.minutes >= LAST_MINUTE) ? 6'd0 : t.minutes + 6'd1;
            if (r.minutes == 6'd0)
            begin
                r.hours = (t.hours >= LAST_HOUR) ? 5'd0 : t.hours + 5'd1;
            end
        end
        else
        begin
            r.seconds = t.seconds + 6'd1;
        end
        return r;
    endfunction

    logic        setup;
    logic [10:0] sub_sum;
    logic        sub_wrap;
    logic [8:0]  blink_sum;
    logic        blink_wrap;
    logic [5:0]  idle;
    logic        upd, en, dis, minev, mark;
    state_t      nx;

    assign setup      = (st.edit_field != FIELD_NONE);
    assign sub_sum    = {1'b0, st.sub_second_count} + 11'd1;
    assign sub_wrap   = (sub_sum >= {1'b0, cfg.ticks_per_second});
    assign blink_sum  = {1'b0, st.blink_count} + 9'd1;
    assign blink_wrap = (blink_sum >= {1'b0, cfg.ticks_per_blink});

    always_comb
    begin
        nx    = st;
        idle  = st.idle_seconds;
        upd   = 1'b0;
        en    = 1'b0;
        dis   = 1'b0;
        minev = 1'b0;
        mark  = 1'b0;
        case (item.kind)
            KIND_TICK:
            begin
                if (cfg.power_save)
                begin
                    nx.tod = next_second(st.tod);
                    mark   = 1'b1;
                end
                else
                begin
                    // key press restarts the timeout
                    if (item.key_pressed)
                    begin
                        en   = 1'b1;
                        idle = '0;
                    end
                    // second prescaler
                    nx.sub_second_count = sub_wrap ? 10'd0 : sub_sum[9:0];
                    if (sub_wrap)
                    begin
                        if (idle < cfg.off_delay)
                        begin
                            idle = idle + 6'd1;
                            if (idle >= cfg.off_delay && st.visible && !setup)
                            begin
                                dis = 1'b1;
                            end
                        end
                        minev       = (st.tod.seconds >= LAST_SECOND);
                        nx.tod      = next_second(st.tod);
                        nx.show_dot = ~st.show_dot;
                        if (!setup)
                        begin
                            nx.show_hour   = 1'b1;
                            nx.show_minute = 1'b1;
                            upd            = st.visible;
                        end
                    end
                    nx.idle_seconds = idle;
                    // blink prescaler, edited field flashes
                    nx.blink_count = blink_wrap ? 8'd0 : blink_sum[7:0];
                    if (setup && blink_wrap)
                    begin
                        if (st.edit_field == FIELD_MINUTE)
                        begin
                            nx.show_hour   = 1'b1;
                            nx.show_minute = ~nx.show_minute;
                        end
                        else if (st.edit_field == FIELD_HOUR)
                        begin
                            nx.show_minute = 1'b1;
                            nx.show_hour   = ~nx.show_hour;
                        end
                        if (st.visible)
                        begin
                            upd = 1'b1;
                        end
                    end
                end
            end
            KIND_ADJUST:
            begin
                if (st.edit_field == FIELD_MINUTE)
                begin
                    if (item.step_down)
                    begin
                        nx.tod.minutes = (st.tod.minutes == 6'd0 ||
                                          st.tod.minutes > LAST_MINUTE) ?
                                         LAST_MINUTE : st.tod.minutes - 6'd1;
                    end
                    else
                    begin
                        nx.tod.minutes = (st.tod.minutes >= LAST_MINUTE) ?
                                         6'd0 : st.tod.minutes + 6'd1;
                    end
                end
                else if (st.edit_field == FIELD_HOUR)
                begin
                    if (item.step_down)
                    begin
                        nx.tod.hours = (st.tod.hours == 5'd0 ||
                                        st.tod.hours > LAST_HOUR) ?
                                       LAST_HOUR : st.tod.hours - 5'd1;
                    end
                    else
                    begin
                        nx.tod.hours = (st.tod.hours >= LAST_HOUR) ?
                                       5'd0 : st.tod.hours + 5'd1;
                    end
                end
            end
            KIND_SET_FLD:
            begin
                nx.edit_field = item.setup_field;
            end
            default:
            begin
                nx.visible = item.visible_in;
            end
        endcase
    end

    assign st_next = nx;

    // result from the state after this item
    always_comb
    begin
        res.hour_out        = nx.tod.hours;
        res.minute_out      = nx.tod.minutes;
        res.second_out      = nx.tod.seconds;
        res.show_hour_out   = nx.show_hour;
        res.show_minute_out = nx.show_minute;
        res.show_dot_out    = nx.show_dot;
        res.display_update  = upd;
        res.display_enable  = en;
        res.display_disable = dis;
        res.minute_event    = minev;
        res.tick_mark       = mark;
    end

endmodule

### src/tdc_outbuf.sv
// ----------------------------------------------------------------------------
// Time-of-day clock result buffer
// Output register plus skid register; takes a result while one waits.
// ----------------------------------------------------------------------------
module tdc_outbuf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tdc_pkg::out_item_t push_data,
    output logic               full,
    output logic               out_valid,
    input  logic               out_ready,
    output tdc_pkg::out_item_t out_data
);
    import tdc_pkg::*;

    logic      head_valid_reg, head_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t head_reg, head_next;
    out_item_t skid_reg, skid_next;
    logic      pop;

    assign pop = head_valid_reg && out_ready;

    // head holds the oldest result, skid the one behind it
    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (head_valid_reg)
        begin
            if (pop && push)
            begin
                head_next = push_data;
            end
            else if (push)
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
            else if (pop)
            begin
                head_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            head_next       = push_data;
            head_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;

endmodule

### src/time_of_day_clock_with_setup_blink_top.sv
// ----------------------------------------------------------------------------
// Time-of-day clock with setup blink
// Result: an item's result is registered into the output register, shown on
// out_data in the next cycle when no earlier result waits on the result channel.
// Throughput: one item per cycle while in_ready is high, one pass of logic from
// state to result reg; in_ready drops only while output and skid regs hold results.
// Reset: time 12:00:00, prescalers and timeout 0, hour and minute shown,
// dot off, hidden, no field edited; registers to their documented defaults.
// ----------------------------------------------------------------------------
`include "time_of_day_clock_with_setup_blink_top_defines.svh"

module time_of_day_clock_with_setup_blink_top (
    input  logic               clk,
    input  logic               rst_n,
    // item channel
    input  logic               in_valid,
    output logic               in_ready,
    input  tdc_pkg::in_item_t  in_data,
    // result channel
    output logic               out_valid,
    input  logic               out_ready,
    output tdc_pkg::out_item_t out_data,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tdc_pkg::*;

    cfg_t      cfg_reg;
    state_t    st_reg;
    state_t    st_next;
    out_item_t res;
    logic      in_fire;
    logic      buf_full;
    logic      cfg_wr;
    logic [1:0] reg_idx;
    logic       time_in_range;
    logic       presc_hold_case;
    logic       adjust_idle_case;
    logic [17:0] presc_pair;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_save       <= 1'b0;
            cfg_reg.ticks_per_second <= TPS_RESET;
            cfg_reg.ticks_per_blink  <= TPB_RESET;
            cfg_reg.off_delay        <= OFF_DLY_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_POWER_SAVE: cfg_reg.power_save       <= pwdata[0];
                REG_TICKS_SEC:  cfg_reg.ticks_per_second <= pwdata[9:0];
                REG_TICKS_BLNK: cfg_reg.ticks_per_blink  <= pwdata[7:0];
                default:        cfg_reg.off_delay        <= pwdata[5:0];
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_POWER_SAVE: prdata = {31'd0, cfg_reg.power_save};
            REG_TICKS_SEC:  prdata = {22'd0, cfg_reg.ticks_per_second};
            REG_TICKS_BLNK: prdata = {24'd0, cfg_reg.ticks_per_blink};
            default:        prdata = {26'd0, cfg_reg.off_delay};
        endcase
    end

    assign in_ready = !buf_full;
    assign in_fire  = in_valid && in_ready;

    tdc_step u_step (
        .st      (st_reg),
        .cfg     (cfg_reg),
        .item    (in_data),
        .st_next (st_next),
        .res     (res)
    );

    // clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.sub_second_count <= '0;
            st_reg.blink_count      <= '0;
            st_reg.tod.hours        <= HOUR_RESET;
            st_reg.tod.minutes      <= '0;
            st_reg.tod.seconds      <= '0;
            st_reg.idle_seconds     <= '0;
            st_reg.show_hour        <= 1'b1;
            st_reg.show_minute      <= 1'b1;
            st_reg.show_dot         <= 1'b0;
            st_reg.visible          <= 1'b0;
            st_reg.edit_field       <= FIELD_NONE;
        end
        else if (in_fire)
        begin
            st_reg <= st_next;
        end
    end

    tdc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // check terms
    assign time_in_range    = (st_reg.tod.minutes <= LAST_MINUTE) &&
                              (st_reg.tod.seconds <= LAST_SECOND);
    assign presc_hold_case  = in_fire && !(in_data.kind == KIND_TICK && !cfg_reg.power_save);
    assign adjust_idle_case = in_fire && (in_data.kind == KIND_ADJUST) &&
                              (st_reg.edit_field == FIELD_NONE);
    assign presc_pair       = {st_reg.sub_second_count, st_reg.blink_count};

    // checks
    `TDC_ASSERT_ALWAYS(a_hour_range, st_reg.tod.hours <= LAST_HOUR, "hour out of range")
    `TDC_ASSERT_ALWAYS(a_min_sec_range, time_in_range, "minute or second out of range")
    `TDC_ASSERT_ALWAYS(a_stall_has_result, in_ready || out_valid, "stall with nothing pending")
    `TDC_ASSERT_NEXT(a_presc_hold, presc_hold_case, $stable(presc_pair), "prescaler moved")
    `TDC_ASSERT_NEXT(a_adjust_idle, adjust_idle_case, $stable(st_reg.tod), "adjust moved time")

endmodule

### sim/time_of_day_clock_with_setup_blink_top_test.sv
// ----------------------------------------------------------------------------
// Time-of-day clock testbench
// Feeds ticks, adjust steps and control writes through the item channel while
// both sides insert random gaps (none in steady phases), predicts every result
// in a local copy of the clock state, and compares each result field by field.
// Register settings are changed between phases over the register port, with readback checks.
// ----------------------------------------------------------------------------
module time_of_day_clock_with_setup_blink_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tdc_pkg::*;

    // field code outside the documented set, stored as written
    localparam logic [1:0] FIELD_SPARE = 2'd3;
    localparam int          MAX_SHOWN  = 10;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    in_item_t    in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    time_of_day_clock_with_setup_blink_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // predicted clock state and register contents
    state_t    clock_state;
    cfg_t      clock_regs;

    in_item_t  items_waiting[$];
    out_item_t results_due[$];
    out_item_t want_res;

    bit steady_flow = 1'b0;
    int gap_left    = 0;
    int hold_left   = 0;

    int n_issued   = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_errors   = 0;
    int n_settings = 0;
    int n_minutes  = 0;
    int n_offs     = 0;
    int n_marks    = 0;
    int n_redraws  = 0;

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Error bookkeeping
    // ------------------------------------------------------------------------
    task automatic note_error(string msg);
        n_errors++;
        if (n_errors <= MAX_SHOWN)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    task automatic cmp_field(string name, logic [5:0] got, logic [5:0] want);
        if (got !== want)
            note_error($sformatf("result %0d %s: expected %0d, got %0d",
                                 n_results, name, want, got));
    endtask

    // ------------------------------------------------------------------------
    // Clock prediction
    // ------------------------------------------------------------------------
    // one second forward; returns 1 at a minute boundary
    function automatic bit bump_second();
        if (clock_state.tod.seconds >= LAST_SECOND)
        begin
            clock_state.tod.seconds = '0;
            clock_state.tod.minutes = (clock_state.tod.minutes >= LAST_MINUTE) ?
                                      '0 : clock_state.tod.minutes + 6'd1;
            if (clock_state.tod.minutes == '0)
                clock_state.tod.hours = (clock_state.tod.hours >= LAST_HOUR) ?
                                        '0 : clock_state.tod.hours + 5'd1;
            return 1'b1;
        end
        clock_state.tod.seconds = clock_state.tod.seconds + 6'd1;
        return 1'b0;
    endfunction

    function automatic void reset_clock_state();
        clock_regs.power_save       = 1'b0;
        clock_regs.ticks_per_second = TPS_RESET;
        clock_regs.ticks_per_blink  = TPB_RESET;
        clock_regs.off_delay        = OFF_DLY_RESET;
        clock_state                 = '0;
        clock_state.tod.hours       = HOUR_RESET;
        clock_state.show_hour       = 1'b1;
        clock_state.show_minute     = 1'b1;
        clock_state.edit_field      = FIELD_NONE;
    endfunction

    function automatic out_item_t next_clock_result(in_item_t it);
        out_item_t r;
        bit        in_setup;
        int        nxt;
        r = '0;
        case (it.kind)
            KIND_TICK:
            begin
                if (clock_regs.power_save)
                begin
                    void'(bump_second());
                    r.tick_mark = 1'b1;
                end
                else
                begin
                    in_setup = (clock_state.edit_field != FIELD_NONE);
                    if (it.key_pressed)
                    begin
                        r.display_enable         = 1'b1;
                        clock_state.idle_seconds = '0;
                    end
                    // seconds prescaler
                    nxt = int'(clock_state.sub_second_count) + 1;
                    clock_state.sub_second_count =
                        (nxt >= int'(clock_regs.ticks_per_second)) ? '0 : nxt[9:0];
                    if (clock_state.sub_second_count == '0)
                    begin
                        if (clock_state.idle_seconds < clock_regs.off_delay)
                        begin
                            clock_state.idle_seconds = clock_state.idle_seconds + 6'd1;
                            if (clock_state.idle_seconds >= clock_regs.off_delay &&
                                clock_state.visible && !in_setup)
                                r.display_disable = 1'b1;
                        end
                        r.minute_event       = bump_second();
                        clock_state.show_dot = ~clock_state.show_dot;
                        if (!in_setup)
                        begin
                            clock_state.show_hour   = 1'b1;
                            clock_state.show_minute = 1'b1;
                            if (clock_state.visible)
                                r.display_update = 1'b1;
                        end
                    end
                    // blink prescaler
                    nxt = int'(clock_state.blink_count) + 1;
                    clock_state.blink_count =
                        (nxt >= int'(clock_regs.ticks_per_blink)) ? '0 : nxt[7:0];
                    if (in_setup && clock_state.blink_count == '0)
                    begin
                        if (clock_state.edit_field == FIELD_MINUTE)
                        begin
                            clock_state.show_hour   = 1'b1;
                            clock_state.show_minute = ~clock_state.show_minute;
                        end
                        else if (clock_state.edit_field == FIELD_HOUR)
                        begin
                            clock_state.show_minute = 1'b1;
                            clock_state.show_hour   = ~clock_state.show_hour;
                        end
                        if (clock_state.visible)
                            r.display_update = 1'b1;
                    end
                end
            end
            KIND_ADJUST:
            begin
                if (clock_state.edit_field == FIELD_MINUTE)
                begin
                    if (it.step_down)
                        clock_state.tod.minutes = (clock_state.tod.minutes == '0 ||
                            clock_state.tod.minutes > LAST_MINUTE) ?
                            LAST_MINUTE : clock_state.tod.minutes - 6'd1;
                    else
                        clock_state.tod.minutes = (clock_state.tod.minutes >= LAST_MINUTE) ?
                            '0 : clock_state.tod.minutes + 6'd1;
                end
                else if (clock_state.edit_field == FIELD_HOUR)
                begin
                    if (it.step_down)
                        clock_state.tod.hours = (clock_state.tod.hours == '0 ||
                            clock_state.tod.hours > LAST_HOUR) ?
                            LAST_HOUR : clock_state.tod.hours - 5'd1;
                    else
                        clock_state.tod.hours = (clock_state.tod.hours >= LAST_HOUR) ?
                            '0 : clock_state.tod.hours + 5'd1;
                end
            end
            KIND_SET_FLD: clock_state.edit_field = it.setup_field;
            default:      clock_state.visible    = it.visible_in;
        endcase
        r.hour_out        = clock_state.tod.hours;
        r.minute_out      = clock_state.tod.minutes;
        r.second_out      = clock_state.tod.seconds;
        r.show_hour_out   = clock_state.show_hour;
        r.show_minute_out = clock_state.show_minute;
        r.show_dot_out    = clock_state.show_dot;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Item driver: predicts each transfer as it is accepted
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                results_due.push_back(next_clock_result(in_data));
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (items_waiting.size() != 0)
                begin
                    in_data  <= items_waiting.pop_front();
                    in_valid <= 1'b1;
                    gap_left = pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor with random back-pressure
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                    note_error($sformatf("result %0d arrived with nothing due", n_results));
                else
                begin
                    want_res = results_due.pop_front();
                    cmp_field("hour_out", 6'(out_data.hour_out), 6'(want_res.hour_out));
                    cmp_field("minute_out", out_data.minute_out, want_res.minute_out);
                    cmp_field("second_out", out_data.second_out, want_res.second_out);
                    cmp_field("show_hour_out", 6'(out_data.show_hour_out),
                              6'(want_res.show_hour_out));
                    cmp_field("show_minute_out", 6'(out_data.show_minute_out),
                              6'(want_res.show_minute_out));
                    cmp_field("show_dot_out", 6'(out_data.show_dot_out),
                              6'(want_res.show_dot_out));
                    cmp_field("display_update", 6'(out_data.display_update),
                              6'(want_res.display_update));
                    cmp_field("display_enable", 6'(out_data.display_enable),
                              6'(want_res.display_enable));
                    cmp_field("display_disable", 6'(out_data.display_disable),
                              6'(want_res.display_disable));
                    cmp_field("minute_event", 6'(out_data.minute_event),
                              6'(want_res.minute_event));
                    cmp_field("tick_mark", 6'(out_data.tick_mark), 6'(want_res.tick_mark));
                    n_minutes += int'(want_res.minute_event);
                    n_offs    += int'(want_res.display_disable);
                    n_marks   += int'(want_res.tick_mark);
                    n_redraws += int'(want_res.display_update);
                end
                n_results++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 99) < 30)
                    hold_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------------
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        logic [31:0] stored;
        case (idx)
            REG_POWER_SAVE:
            begin
                stored = {31'b0, val[0]};
                clock_regs.power_save = val[0];
            end
            REG_TICKS_SEC:
            begin
                stored = {22'b0, val[9:0]};
                clock_regs.ticks_per_second = val[9:0];
            end
            REG_TICKS_BLNK:
            begin
                stored = {24'b0, val[7:0]};
                clock_regs.ticks_per_blink = val[7:0];
            end
            default:
            begin
                stored = {26'b0, val[5:0]};
                clock_regs.off_delay = val[5:0];
            end
        endcase
        // write transfer
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // readback transfer
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== stored)
            note_error($sformatf("register %0d readback: expected %0d, got %0d",
                                 idx, stored, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_regs(logic ps, logic [9:0] tps, logic [7:0] tpb, logic [5:0] dly);
        reg_write(REG_POWER_SAVE, {31'b0, ps});
        reg_write(REG_TICKS_SEC, {22'b0, tps});
        reg_write(REG_TICKS_BLNK, {24'b0, tpb});
        reg_write(REG_OFF_DELAY, {26'b0, dly});
        n_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send(in_item_t it);
        items_waiting.push_back(it);
        n_issued++;
    endtask

    function automatic in_item_t make_item(logic [1:0] kind, logic key, logic down,
                                           logic [1:0] fld, logic vis);
        in_item_t it;
        it.kind        = kind;
        it.key_pressed = key;
        it.step_down   = down;
        it.setup_field = fld;
        it.visible_in  = vis;
        return it;
    endfunction

    // mostly ticks, with edits and control writes mixed in
    task automatic send_random(int count, int tick_pct);
        in_item_t it;
        int       r;
        repeat (count)
        begin
            it.key_pressed = ($urandom_range(0, 99) < 15);
            it.step_down   = 1'($urandom_range(0, 1));
            it.setup_field = ($urandom_range(0, 99) < 10) ? FIELD_SPARE :
                             2'($urandom_range(0, 2));
            it.visible_in  = ($urandom_range(0, 99) < 75);
            r = $urandom_range(0, 99);
            if (r < tick_pct)
                it.kind = KIND_TICK;
            else if (r < tick_pct + (100 - tick_pct) / 2)
                it.kind = KIND_ADJUST;
            else if (r < tick_pct + (100 - tick_pct) * 3 / 4)
                it.kind = KIND_SET_FLD;
            else
                it.kind = KIND_SET_VIS;
            send(it);
        end
    endtask

    task automatic wait_drained();
        do @(negedge clk); while (n_accepted != n_issued || results_due.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    // steer the time to 23:59 by adjust steps, then tick across midnight
    task automatic midnight_drill(bit go_down, int ticks);
        int steps;
        wait_drained();
        send(make_item(KIND_SET_FLD, 1'b0, 1'b0, FIELD_HOUR, 1'b0));
        steps = go_down ? (int'(clock_state.tod.hours) + 1) % 24 :
                          23 - int'(clock_state.tod.hours);
        repeat (steps) send(make_item(KIND_ADJUST, 1'b0, go_down, FIELD_NONE, 1'b0));
        send(make_item(KIND_SET_FLD, 1'b0, 1'b0, FIELD_MINUTE, 1'b0));
        steps = go_down ? (int'(clock_state.tod.minutes) + 1) % 60 :
                          59 - int'(clock_state.tod.minutes);
        repeat (steps) send(make_item(KIND_ADJUST, 1'b0, go_down, FIELD_NONE, 1'b0));
        send(make_item(KIND_SET_FLD, 1'b0, 1'b0, FIELD_NONE, 1'b0));
        send(make_item(KIND_SET_VIS, 1'b0, 1'b0, FIELD_NONE, 1'b1));
        repeat (ticks) send(make_item(KIND_TICK, 1'b0, 1'b0, FIELD_NONE, 1'b0));
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        reset_clock_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pass under reset register values
        steady_flow = 1'b1;
        send(make_item(KIND_TICK, 1'b0, 1'b0, FIELD_NONE, 1'b0));
        send(make_item(KIND_TICK, 1'b1, 1'b0, FIELD_NONE, 1'b0));
        send(make_item(KIND_SET_VIS, 1'b0, 1'b0, FIELD_NONE, 1'b1));
        // adjust outside setup does nothing
        send(make_item(KIND_ADJUST, 1'b0, 1'b0, FIELD_NONE, 1'b0));
        send(make_item(KIND_ADJUST, 1'b1, 1'b1, FIELD_SPARE, 1'b1));
        // spare field code: setup mode with no field to edit
        send(make_item(KIND_SET_FLD, 1'b0, 1'b0, FIELD_SPARE, 1'b0));
        send(make_item(KIND_ADJUST, 1'b0, 1'b1, FIELD_NONE, 1'b0));
        send(make_item(KIND_TICK, 1'b1, 1'b1, FIELD_SPARE, 1'b1));
        // minute edits, down wrap from zero and back up
        send(make_item(KIND_SET_FLD, 1'b0, 1'b0, FIELD_MINUTE, 1'b0));
        send(make_item(KIND_ADJUST, 1'b0, 1'b1, FIELD_NONE, 1'b0));
        send(make_item(KIND_ADJUST, 1'b0, 1'b0, FIELD_NONE, 1'b0));
        send(make_item(KIND_ADJUST, 1'b0, 1'b0, FIELD_NONE, 1'b0));
        send(make_item(KIND_TICK, 1'b0, 1'b0, FIELD_NONE, 1'b0));
        // hour edits
        send(make_item(KIND_SET_FLD, 1'b0, 1'b0, FIELD_HOUR, 1'b0));
        send(make_item(KIND_ADJUST, 1'b0, 1'b1, FIELD_NONE, 1'b0));
        send(make_item(KIND_ADJUST, 1'b0, 1'b0, FIELD_NONE, 1'b0));
        send(make_item(KIND_ADJUST, 1'b1, 1'b0, FIELD_SPARE, 1'b1));
        send(make_item(KIND_TICK, 1'b0, 1'b0, FIELD_NONE, 1'b0));
        send(make_item(KIND_SET_FLD, 1'b0, 1'b0, FIELD_NONE, 1'b0));
        send(make_item(KIND_SET_VIS, 1'b1, 1'b1, FIELD_SPARE, 1'b0));
        send(make_item(KIND_TICK, 1'b1, 1'b0, FIELD_NONE, 1'b0));
        wait_drained();

        // low extremes: every tick is a second and a blink
        steady_flow = 1'b0;
        set_regs(1'b0, 10'd1, 8'd1, 6'd1);
        send_random(70, 70);
        wait_drained();

        // short timeout with back-to-back traffic
        steady_flow = 1'b1;
        set_regs(1'b0, 10'd3, 8'd2, 6'd5);
        send_random(70, 75);
        wait_drained();

        // power save: every tick one second
        steady_flow = 1'b0;
        set_regs(1'b1, 10'd3, 8'd2, 6'd5);
        midnight_drill(1'b1, 61);
        send_random(40, 60);
        wait_drained();

        // high extremes: prescalers build up large counts
        set_regs(1'b0, 10'd1023, 8'd255, 6'd60);
        send_random(40, 80);
        wait_drained();

        // lowered limits below the running counts wrap at once
        set_regs(1'b0, 10'd2, 8'd3, 6'd60);
        send_random(70, 75);
        wait_drained();

        // zero registers: always wrapping, timeout disabled
        set_regs(1'b0, 10'd0, 8'd0, 6'd0);
        send_random(40, 75);
        wait_drained();

        // normal-mode midnight and a timeout beyond the usual range
        set_regs(1'b0, 10'd1, 8'd7, 6'd63);
        midnight_drill(1'($urandom_range(0, 1)), 61);
        send_random(70, 70);
        wait_drained();

        repeat (10) @(posedge clk);
        $display("Covered %0d items and %0d results over %0d register settings.",
                 n_accepted, n_results, n_settings);
        $display("Seen: %0d minute events, %0d display-offs, %0d save-mode seconds, %0d redraws.",
                 n_minutes, n_offs, n_marks, n_redraws);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d items waiting and %0d results due.",
                 items_waiting.size(), results_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/tdc_pkg.sv
src/tdc_step.sv
src/tdc_outbuf.sv
src/time_of_day_clock_with_setup_blink_top.sv
sim/time_of_day_clock_with_setup_blink_top_test.sv
